FILE: rtl/mtg_pkg.sv
// ----------------------------------------------------------------------------
// mtg_pkg: shared definitions of the Mersenne Twister generator
// Constants, operation codes and the twist and tempering functions.
// ----------------------------------------------------------------------------
package mtg_pkg;

  localparam int unsigned DefStateWords = 624;
  localparam int unsigned TwistOffset   = 397;
  localparam int unsigned WordW         = 32;

  localparam logic [WordW-1:0] TwistMatrix = 32'h9908_B0DF;
  localparam logic [WordW-1:0] HighBitMask = 32'h8000_0000;
  localparam logic [WordW-1:0] LowBitsMask = 32'h7FFF_FFFF;
  localparam logic [WordW-1:0] SeedMult    = 32'd69069;
  localparam logic [WordW-1:0] TemperB     = 32'h9D2C_5680;
  localparam logic [WordW-1:0] TemperC     = 32'hEFC6_0000;

  typedef logic [WordW-1:0] word_t;

  // Operation carried in tuser
  typedef enum logic [0:0] {
    FUNC_DRAW = 1'b0,
    FUNC_SEED = 1'b1
  } func_e;

  // Controller states, one-hot
  typedef enum logic [1:0] {
    ST_RUN  = 2'b01,
    ST_SEED = 2'b10
  } state_e;

  // New word from the head, its neighbor and the far tap
  function automatic word_t twist_word(word_t head, word_t nxt, word_t far);
    word_t y;
    word_t v;
    y = (head & HighBitMask) | (nxt & LowBitsMask);
    v = far ^ (y >> 1);
    if (y[0]) begin
      v = v ^ TwistMatrix;
    end
    return v;
  endfunction

  // Output tempering
  function automatic word_t temper(word_t w);
    word_t y;
    y = w;
    y = y ^ (y >> 11);
    y = y ^ ((y << 7) & TemperB);
    y = y ^ ((y << 15) & TemperC);
    y = y ^ (y >> 18);
    return y;
  endfunction

endpackage

FILE: rtl/mtg_cell.sv
// ----------------------------------------------------------------------------
// mtg_cell: one state word of the shift ring
// Holds a 32-bit word and takes its neighbor's word on each shift.
// ----------------------------------------------------------------------------
module mtg_cell (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               shift_i,
  input  mtg_pkg::word_t     data_i,
  output mtg_pkg::word_t     data_o
);
  import mtg_pkg::*;

  word_t word_q;
  word_t word_d;

  // Take the neighbor's word on a shift, hold otherwise
  always_comb begin
    word_d = shift_i ? data_i : word_q;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      word_q <= '0;
    end else begin
      word_q <= word_d;
    end
  end

  assign data_o = word_q;

endmodule

FILE: rtl/mtg_twist.sv
// ----------------------------------------------------------------------------
// mtg_twist: twist and tempering unit
// Forms the next state word from three ring taps and tempers it.
// ----------------------------------------------------------------------------
module mtg_twist (
  input  mtg_pkg::word_t head_i,
  input  mtg_pkg::word_t next_i,
  input  mtg_pkg::word_t far_i,
  output mtg_pkg::word_t word_o,
  output mtg_pkg::word_t tempered_o
);
  import mtg_pkg::*;

  // Twist the head word, then temper the result
  always_comb begin
    word_o     = twist_word(head_i, next_i, far_i);
    tempered_o = temper(word_o);
  end

endmodule

FILE: rtl/mersenne_twister_generator.sv
// ----------------------------------------------------------------------------
// mersenne_twister_generator: MT19937 32-bit generator on a shift ring
// Draw: one item per cycle while not seed-filling and the output is free;
//   result registered, valid the cycle after acceptance. Seed: into the tail,
//   then the ring fills one word per cycle by the seed multiplier; no result.
// Each draw twists the head word into the tail, so a full regeneration is
//   spread over STATE_WORDS draws. Reset clears all words asynchronously.
// ----------------------------------------------------------------------------
module mersenne_twister_generator #(
  parameter int unsigned STATE_WORDS = mtg_pkg::DefStateWords
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                s_axis_tvalid_i,
  output logic                s_axis_tready_o,
  input  mtg_pkg::word_t      s_axis_tdata_i,   // [31:0] seed_value
  input  logic                s_axis_tuser_i,   // [0] func
  output logic                m_axis_tvalid_o,
  input  logic                m_axis_tready_i,
  output mtg_pkg::word_t      m_axis_tdata_o    // [31:0] random_value
);
  import mtg_pkg::*;

  localparam int unsigned CntW = $clog2(STATE_WORDS + 1);
  localparam int unsigned Last = STATE_WORDS - 1;

  state_e          state_q, state_d;
  logic [CntW-1:0] cnt_q, cnt_d;
  logic            out_valid_q, out_valid_d;
  word_t           out_data_q, out_data_d;

  word_t           chain [STATE_WORDS];
  word_t           tail_d;
  word_t           twisted;
  word_t           tempered;
  word_t           seed_next;
  logic            shift;
  logic            in_acc;
  logic            draw_acc;
  logic            seed_acc;
  logic            out_free;

  // Handshake decode
  assign out_free        = !out_valid_q || m_axis_tready_i;
  assign s_axis_tready_o = (state_q == ST_RUN) &&
                           (s_axis_tuser_i == FUNC_SEED || out_free);
  assign in_acc          = s_axis_tvalid_i && s_axis_tready_o;
  assign draw_acc        = in_acc && (s_axis_tuser_i == FUNC_DRAW);
  assign seed_acc        = in_acc && (s_axis_tuser_i == FUNC_SEED);

  // Row of state cells, each taking its upper neighbor's word, the last the tail input
  for (genvar i = 0; i < STATE_WORDS; i++) begin : g_cell
    word_t cell_in;
    if (i == Last) begin : g_tail
      assign cell_in = tail_d;
    end else begin : g_body
      assign cell_in = chain[i+1];
    end
    mtg_cell u_cell (
      .clk_i  (clk_i),
      .rst_ni (rst_ni),
      .shift_i(shift),
      .data_i (cell_in),
      .data_o (chain[i])
    );
  end

  // Twist from the fixed taps
  mtg_twist u_twist (
    .head_i    (chain[0]),
    .next_i    (chain[1]),
    .far_i     (chain[TwistOffset]),
    .word_o    (twisted),
    .tempered_o(tempered)
  );

  // Seed chain: next word from the last word pushed
  assign seed_next = chain[Last] * SeedMult;

  // Sequencer: pick the tail input and advance the seed fill
  always_comb begin
    state_d = state_q;
    cnt_d   = cnt_q;
    shift   = 1'b0;
    tail_d  = twisted;
    case (state_q)
      ST_RUN: begin
        if (seed_acc) begin
          shift   = 1'b1;
          tail_d  = s_axis_tdata_i;
          cnt_d   = CntW'(1);
          state_d = ST_SEED;
        end else if (draw_acc) begin
          shift  = 1'b1;
          tail_d = twisted;
        end
      end
      ST_SEED: begin
        shift  = 1'b1;
        tail_d = seed_next;
        cnt_d  = cnt_q + CntW'(1);
        if (cnt_q == CntW'(Last)) begin
          state_d = ST_RUN;
        end
      end
      default: begin
        state_d = ST_RUN;
      end
    endcase
  end

  // Output register: load on draw, drop when taken
  always_comb begin
    out_valid_d = out_valid_q;
    out_data_d  = out_data_q;
    if (draw_acc) begin
      out_valid_d = 1'b1;
      out_data_d  = tempered;
    end else if (m_axis_tready_i) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_RUN;
      cnt_q       <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      cnt_q       <= cnt_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    out_data_q <= out_data_d;
  end

  assign m_axis_tvalid_o = out_valid_q;
  assign m_axis_tdata_o  = out_data_q;

  // Checks
  a_seed_blocks_input : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_SEED) |-> !s_axis_tready_o)
    else $error("input accepted during seed fill");

  a_seed_enters_fill : assert property (@(posedge clk_i) disable iff (!rst_ni)
    seed_acc |=> (state_q == ST_SEED))
    else $error("seed item did not start the fill");

  a_draw_gives_result : assert property (@(posedge clk_i) disable iff (!rst_ni)
    draw_acc |=> m_axis_tvalid_o)
    else $error("draw item gave no result");

  a_seed_no_result : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (seed_acc && !out_valid_q) |=> !m_axis_tvalid_o)
    else $error("seed item gave a result");

  a_fill_count : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_SEED) |-> (cnt_q != '0) && (cnt_q <= CntW'(Last)))
    else $error("seed fill count out of range");

endmodule

FILE: tb/mersenne_twister_generator_test.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// mersenne_twister_generator_test: stream-level check of the MT19937 generator
// Drives seed and draw items on the input stream, predicts every drawn word
// with a self-contained software twister, and compares each output item in
// order. Both stream sides idle at random, with one long back-pressure hold
// and one full drain pause during the random part.
// ----------------------------------------------------------------------------
module mersenne_twister_generator_test;

  import mtg_pkg::*;

  localparam int unsigned PoolWords   = DefStateWords;
  localparam int unsigned RandomItems = 1100;
  localparam int unsigned HoldCycles  = 300;
  localparam int unsigned CycleLimit  = 2000000;
  localparam int unsigned IdlePercent = 28;

  // --------------------------------------------------------------------------
  // Scoreboard: software twister plus the queue of words still to come out
  // --------------------------------------------------------------------------
  class mt_scoreboard;
    word_t       pool [PoolWords];
    logic [9:0]  draw_pos;
    word_t       expected_words [$];
    int unsigned mismatch_count;

    function new();
      foreach (pool[k]) pool[k] = '0;
      draw_pos       = '0;
      mismatch_count = 0;
    endfunction

    // Rebuild the whole pool in place through the twist recurrence
    function void twist_pool();
      word_t mixed;
      word_t fresh;
      int unsigned nxt;
      int unsigned far;
      for (int unsigned k = 0; k < PoolWords; k++) begin
        nxt   = (k + 1) % PoolWords;
        far   = (k + TwistOffset) % PoolWords;
        mixed = {pool[k][WordW-1], pool[nxt][WordW-2:0]};
        fresh = pool[far] ^ {1'b0, mixed[WordW-1:1]};
        if (mixed[0]) begin
          fresh = fresh ^ TwistMatrix;
        end
        pool[k] = fresh;
      end
    endfunction

    // Output scrambling of one pool word
    function word_t tempered(word_t w);
      word_t t;
      t = w ^ {11'b0, w[WordW-1:11]};
      t = t ^ ({t[WordW-8:0], 7'b0} & TemperB);
      t = t ^ ({t[WordW-16:0], 15'b0} & TemperC);
      return t ^ {18'b0, t[WordW-1:18]};
    endfunction

    // Advance the model by one accepted input item
    function void note_item(func_e op, word_t seed);
      if (op == FUNC_SEED) begin
        pool[0] = seed;
        for (int unsigned k = 1; k < PoolWords; k++) begin
          pool[k] = pool[k-1] * SeedMult;
        end
        draw_pos = 10'(PoolWords);
      end else begin
        if (draw_pos >= PoolWords) begin
          twist_pool();
          draw_pos = '0;
        end
        expected_words.push_back(tempered(pool[draw_pos]));
        draw_pos = draw_pos + 1'b1;
      end
    endfunction

    function int unsigned pending();
      return expected_words.size();
    endfunction

    task report_mismatch(string msg);
      mismatch_count++;
      $display("MISMATCH: %s", msg);
    endtask

    // Compare one output item with the oldest prediction
    task check_result(word_t got);
      word_t want;
      if (expected_words.size() == 0) begin
        report_mismatch($sformatf("unexpected output item %08h", got));
      end else begin
        want = expected_words.pop_front();
        if (got !== want) begin
          report_mismatch($sformatf("random_value %08h, predicted %08h", got, want));
        end
      end
    endtask
  endclass

  // --------------------------------------------------------------------------
  // Clock, reset and block under test
  // --------------------------------------------------------------------------
  logic  clk_i = 1'b0;
  logic  rst_ni;
  logic  s_axis_tvalid_i;
  logic  s_axis_tready_o;
  word_t s_axis_tdata_i;    // [31:0] seed_value
  logic  s_axis_tuser_i;    // [0] func
  logic  m_axis_tvalid_o;
  logic  m_axis_tready_i;
  word_t m_axis_tdata_o;    // [31:0] random_value

  mt_scoreboard sb;
  logic         calm;          // no idling on either side while set
  logic         hold_off_req;  // ask the sink for one long hold-off
  int unsigned  cycle_count;

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  mersenne_twister_generator u_dut (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .s_axis_tvalid_i (s_axis_tvalid_i),
    .s_axis_tready_o (s_axis_tready_o),
    .s_axis_tdata_i  (s_axis_tdata_i),
    .s_axis_tuser_i  (s_axis_tuser_i),
    .m_axis_tvalid_o (m_axis_tvalid_o),
    .m_axis_tready_i (m_axis_tready_i),
    .m_axis_tdata_o  (m_axis_tdata_o)
  );

  // --------------------------------------------------------------------------
  // Output side: random ready, one long hold-off on request
  // --------------------------------------------------------------------------
  initial begin
    bit hold_done;
    hold_done       = 1'b0;
    m_axis_tready_i = 1'b0;
    forever begin
      @(posedge clk_i);
      if (hold_off_req && !hold_done) begin
        m_axis_tready_i <= 1'b0;
        for (int unsigned n = 0; n < HoldCycles; n++) begin
          @(posedge clk_i);
        end
        hold_done = 1'b1;
      end
      m_axis_tready_i <= calm || ($urandom_range(0, 99) >= IdlePercent);
    end
  end

  // Check every output item taken
  always @(posedge clk_i) begin
    if (rst_ni && m_axis_tvalid_o && m_axis_tready_i) begin
      sb.check_result(m_axis_tdata_o);
    end
  end

  // Abort a hung run
  initial begin
    cycle_count = 0;
    while (cycle_count < CycleLimit) begin
      @(posedge clk_i);
      cycle_count++;
    end
    $display("simulation failed");
    $finish;
  end

  // --------------------------------------------------------------------------
  // Input side
  // --------------------------------------------------------------------------
  // Offer one item after random idle cycles and hold it until taken
  task send_item(func_e op, word_t data);
    while (!calm && ($urandom_range(0, 99) < IdlePercent)) begin
      s_axis_tvalid_i <= 1'b0;
      @(posedge clk_i);
    end
    s_axis_tvalid_i <= 1'b1;
    s_axis_tuser_i  <= op;
    s_axis_tdata_i  <= data;
    @(posedge clk_i);
    while (!s_axis_tready_o) begin
      @(posedge clk_i);
    end
    sb.note_item(op, data);
  endtask

  task wait_drained();
    while (sb.pending() != 0) begin
      @(posedge clk_i);
    end
  endtask

  function word_t pick_seed();
    case ($urandom_range(0, 9))
      0:       return '0;
      1:       return '1;
      2:       return 32'h8000_0000;
      3:       return 32'h0000_0001;
      default: return $urandom();
    endcase
  endfunction

  initial begin
    int unsigned sent;
    int unsigned run_len;
    int unsigned seg;
    bit          drained;

    sb              = new();
    calm            = 1'b0;
    hold_off_req    = 1'b0;
    drained         = 1'b0;
    rst_ni          = 1'b0;
    s_axis_tvalid_i = 1'b0;
    s_axis_tdata_i  = '0;
    s_axis_tuser_i  = FUNC_DRAW;

    repeat (8) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Unseeded draws give zero whatever the data field holds
    send_item(FUNC_DRAW, '1);
    send_item(FUNC_DRAW, '0);
    send_item(FUNC_DRAW, 32'hA5A5_A5A5);
    // A zero seed keeps the pool zero through the regeneration
    send_item(FUNC_SEED, '0);
    repeat (3) send_item(FUNC_DRAW, $urandom());
    // Extreme seeds, two seeds back to back, the usual default seed
    send_item(FUNC_SEED, '1);
    repeat (3) send_item(FUNC_DRAW, '0);
    send_item(FUNC_SEED, 32'h0000_0001);
    send_item(FUNC_SEED, 32'h8000_0000);
    repeat (3) send_item(FUNC_DRAW, 32'h5A5A_5A5A);
    send_item(FUNC_SEED, 32'd5489);
    repeat (3) send_item(FUNC_DRAW, '1);

    // Random part: seeded runs of draws, some long enough to regenerate twice
    sent = 0;
    seg  = 0;
    while (sent < RandomItems) begin
      send_item(FUNC_SEED, pick_seed());
      sent++;
      if ($urandom_range(0, 9) == 0) begin
        send_item(FUNC_SEED, pick_seed());
        sent++;
      end
      if (seg == 0 || $urandom_range(0, 3) == 0) begin
        run_len = $urandom_range(630, 1300);
      end else begin
        run_len = $urandom_range(1, 90);
      end
      seg++;
      for (int unsigned n = 0; n < run_len && sent < RandomItems; n++) begin
        send_item(FUNC_DRAW, $urandom());
        sent++;
        calm = (sent >= 400) && (sent < 600);
        if (sent == 200) begin
          hold_off_req = 1'b1;
        end
        if (sent >= 800 && !drained) begin
          drained = 1'b1;
          s_axis_tvalid_i <= 1'b0;
          @(posedge clk_i);
          wait_drained();
        end
      end
    end
    s_axis_tvalid_i <= 1'b0;

    // Let the last results out, then settle
    wait_drained();
    repeat (50) @(posedge clk_i);
    if (sb.mismatch_count == 0) begin
      $display("simulation ok");
    end else begin
      $display("simulation failed");
    end
    $finish;
  end

endmodule
